// ===== hdl/merge_insertion_sorter_unit_defines.svh =====
// Assertion macros for the merge insertion sorter.
`ifndef MERGE_INSERTION_SORTER_UNIT_DEFINES_SVH
`define MERGE_INSERTION_SORTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define MIS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error("assertion failed");

`define MIS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

`define MIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define MIS_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define MIS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define MIS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/mis_pkg.sv =====
package mis_pkg;

	localparam int VALUE_W = 31;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last_item;
	} item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] sorted_value;
		logic               last_result;
		logic               overflow;
	} res_t;

	typedef struct packed {
		logic load;
		res_t data;
	} res_load_t;

endpackage

// ===== hdl/mis_out_stage.sv =====
module mis_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  mis_pkg::res_load_t ld,
	output logic              rdy,
	output logic              result_valid,
	input  logic              result_stall,
	output mis_pkg::res_t     result
);

	logic          valid_q;
	mis_pkg::res_t data_q;

	assign rdy          = !valid_q || !result_stall;
	assign result_valid = valid_q;
	assign result       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ld.load) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.load) begin
			data_q <= ld.data;
		end
	end

endmodule

// ===== hdl/merge_insertion_sorter_unit.sv =====
// An item is stored at once into an empty set, or dropped when the store is full; otherwise
// the backward scan (read, compare) shifts each larger entry up, then writes the item in the gap
// (a place step if it lands at the front). An item flagged last then emits the set, each
// result by a memory read and an output load; item_stall holds new items until all is done.
// Reset clears the element count, the drop flag and the output valid; store contents persist.
`include "merge_insertion_sorter_unit_defines.svh"

module merge_insertion_sorter_unit #(
	parameter int CAPACITY   = 64,
	parameter int VALUE_BITS = 31
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  mis_pkg::item_t item,
	output logic           result_valid,
	input  logic           result_stall,
	output mis_pkg::res_t  result
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] FULL = CW'(CAPACITY);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_CMP   = 3'd2;
	localparam logic [2:0] ST_PLACE = 3'd3;
	localparam logic [2:0] ST_EM_RD = 3'd4;
	localparam logic [2:0] ST_EM_LD = 3'd5;

	logic [2:0]            state_q;
	logic [CW-1:0]         count_q;
	logic                  dropped_q;
	logic [AW-1:0]         i_q;
	logic [AW-1:0]         k_q;
	logic [VALUE_BITS-1:0] v_q;
	logic                  last_q;
	logic [VALUE_BITS-1:0] rdata_q;
	logic [VALUE_BITS-1:0] mem [CAPACITY];

	logic                  accept;
	logic [63:0]           in_ext;
	logic [63:0]           r_ext;
	logic [VALUE_BITS-1:0] v_in;
	logic                  gt;
	logic                  is_last;
	logic                  out_rdy;
	logic [2:0]            done_state;
	logic                  we;
	logic [AW-1:0]         waddr;
	logic [AW-1:0]         raddr;
	logic [VALUE_BITS-1:0] wdata;
	mis_pkg::res_load_t    ld;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && (state_q == ST_IDLE);
	assign in_ext     = 64'(item.value);
	assign v_in       = in_ext[VALUE_BITS-1:0];
	assign r_ext      = 64'(rdata_q);
	assign gt         = (rdata_q > v_q);
	assign is_last    = ((CW'(k_q) + CW'(1)) == count_q);
	assign done_state = last_q ? ST_EM_RD : ST_IDLE;

	always_comb begin
		we    = 1'b0;
		waddr = i_q;
		wdata = v_q;
		raddr = k_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (count_q == '0)) begin
					we    = 1'b1;
					waddr = '0;
					wdata = v_in;
				end
			end
			ST_READ: begin
				raddr = i_q - AW'(1);
			end
			ST_CMP: begin
				we    = 1'b1;
				wdata = gt ? rdata_q : v_q;
			end
			ST_PLACE: begin
				we    = 1'b1;
				waddr = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			dropped_q <= 1'b0;
			i_q       <= '0;
			k_q       <= '0;
			last_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= item.last_item;
						if (count_q == FULL) begin
							dropped_q <= 1'b1;
							if (item.last_item) begin
								state_q <= ST_EM_RD;
							end
						end else if (count_q == '0) begin
							count_q <= CW'(1);
							if (item.last_item) begin
								state_q <= ST_EM_RD;
							end
						end else begin
							i_q     <= count_q[AW-1:0];
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (gt) begin
						i_q     <= i_q - AW'(1);
						state_q <= (i_q == AW'(1)) ? ST_PLACE : ST_READ;
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= done_state;
					end
				end
				ST_PLACE: begin
					count_q <= count_q + CW'(1);
					state_q <= done_state;
				end
				ST_EM_RD: begin
					state_q <= ST_EM_LD;
				end
				ST_EM_LD: begin
					if (out_rdy) begin
						if (is_last) begin
							count_q   <= '0;
							dropped_q <= 1'b0;
							k_q       <= '0;
							state_q   <= ST_IDLE;
						end else begin
							k_q     <= k_q + AW'(1);
							state_q <= ST_EM_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			v_q <= v_in;
		end
	end

	always_comb begin
		ld.load              = (state_q == ST_EM_LD) && out_rdy;
		ld.data.sorted_value = r_ext[mis_pkg::VALUE_W-1:0];
		ld.data.last_result  = is_last;
		ld.data.overflow     = dropped_q;
	end

	mis_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.ld           (ld),
		.rdy          (out_rdy),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	`MIS_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= FULL)
	`MIS_ASSERT_IMPLIES(a_cmp_index, clk, arst_n, state_q == ST_CMP, i_q != '0)
	`MIS_ASSERT_NEXT(a_drop_flag, clk, arst_n, accept && (count_q == FULL), dropped_q)
	`MIS_ASSERT_IMPLIES(a_emit_nonempty, clk, arst_n, state_q == ST_EM_LD, count_q != '0)

endmodule
